### hdl/mnm_pkg.sv
`timescale 1ns / 1ps

package mnm_pkg;

  // Default capacities and fixed field widths
  localparam int MNM_MAX_POINTS_A = 32;
  localparam int MNM_MAX_POINTS_B = 32;
  localparam int COORD_BITS       = 16;
  localparam int OUT_IDX_W        = 5;

  // Operation codes on the input channel
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] point_index;
    logic [OUT_IDX_W-1:0] match_index;
    logic                 matched;
    logic                 last;
    logic                 none_loaded;
    logic                 overflowed;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic phase2;
    logic latch_ref;
    logic scan_valid;
    logic scan_first;
    logic scan_last;
    logic wr_na;
    logic emit;
    logic emit_last;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

### hdl/mnm_ram.sv
`timescale 1ns / 1ps

module mnm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/mnm_ctrl.sv
`timescale 1ns / 1ps

module mnm_ctrl
  import mnm_pkg::*;
#(
  parameter int IDX_W  = 5,
  parameter int CNTA_W = 6,
  parameter int CNTB_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  input  logic [CNTA_W-1:0] a_count,
  input  logic [CNTB_W-1:0] b_count,
  input  stat_t             stat,
  output cmd_t              cmd,
  output logic [IDX_W-1:0]  a_addr,
  output logic [IDX_W-1:0]  b_addr
);

  localparam int CW = IDX_W + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_P1_REF  = 8'b0000_0010,
    S_P1_SCAN = 8'b0000_0100,
    S_P1_WAIT = 8'b0000_1000,
    S_P2_REF  = 8'b0001_0000,
    S_P2_SCAN = 8'b0010_0000,
    S_P2_WAIT = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] outer_r, outer_nxt;
  logic [IDX_W-1:0] inner_r, inner_nxt;

  logic          phase1;
  logic          a_empty, b_empty;
  logic [CW-1:0] a_cnt_ext, b_cnt_ext;
  logic [CW-1:0] inner_inc, outer_inc;
  logic          inner_last_a, inner_last_b, outer_last_a, outer_last_b;

  // Loop bounds against the set counts
  always_comb begin
    a_cnt_ext    = CW'(a_count);
    b_cnt_ext    = CW'(b_count);
    inner_inc    = {1'b0, inner_r} + CW'(1);
    outer_inc    = {1'b0, outer_r} + CW'(1);
    inner_last_a = (inner_inc == a_cnt_ext);
    inner_last_b = (inner_inc == b_cnt_ext);
    outer_last_a = (outer_inc == a_cnt_ext);
    outer_last_b = (outer_inc == b_cnt_ext);
    a_empty      = (a_count == '0);
    b_empty      = (b_count == '0);
  end

  // Phase one scans A for each B point, phase two scans B for each A point
  assign phase1   = (state_r == S_P1_REF) || (state_r == S_P1_SCAN) || (state_r == S_P1_WAIT);
  assign a_addr   = phase1 ? inner_r : outer_r;
  assign b_addr   = phase1 ? outer_r : inner_r;
  assign in_stall = (state_r != S_IDLE);

  // Sequence the run
  always_comb begin
    cmd        = '0;
    cmd.phase2 = !phase1;
    state_nxt  = state_r;
    outer_nxt  = outer_r;
    inner_nxt  = inner_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_RUN: begin
              outer_nxt = '0;
              state_nxt = (a_empty || b_empty) ? S_EMIT : S_P1_REF;
            end
            default: ;
          endcase
        end
      end
      S_P1_REF: begin
        inner_nxt = '0;
        state_nxt = S_P1_SCAN;
      end
      S_P1_SCAN: begin
        cmd.scan_valid = 1'b1;
        cmd.scan_first = (inner_r == '0);
        cmd.latch_ref  = (inner_r == '0);
        cmd.scan_last  = inner_last_a;
        if (inner_last_a) begin
          state_nxt = S_P1_WAIT;
        end else begin
          inner_nxt = inner_r + IDX_W'(1);
        end
      end
      S_P1_WAIT: begin
        if (stat.scan_done) begin
          cmd.wr_na = 1'b1;
          if (outer_last_b) begin
            outer_nxt = '0;
            state_nxt = S_P2_REF;
          end else begin
            outer_nxt = outer_r + IDX_W'(1);
            state_nxt = S_P1_REF;
          end
        end
      end
      S_P2_REF: begin
        inner_nxt = '0;
        state_nxt = S_P2_SCAN;
      end
      S_P2_SCAN: begin
        cmd.scan_valid = 1'b1;
        cmd.scan_first = (inner_r == '0);
        cmd.latch_ref  = (inner_r == '0);
        cmd.scan_last  = inner_last_b;
        if (inner_last_b) begin
          state_nxt = S_P2_WAIT;
        end else begin
          inner_nxt = inner_r + IDX_W'(1);
        end
      end
      S_P2_WAIT: begin
        if (stat.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = a_empty || outer_last_a;
          if (a_empty || outer_last_a) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            outer_nxt = outer_r + IDX_W'(1);
            state_nxt = b_empty ? S_EMIT : S_P2_REF;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    outer_r <= outer_nxt;
    inner_r <= inner_nxt;
  end

endmodule

### hdl/mnm_dp.sv
`timescale 1ns / 1ps

module mnm_dp
  import mnm_pkg::*;
#(
  parameter int MAX_POINTS_A = MNM_MAX_POINTS_A,
  parameter int MAX_POINTS_B = MNM_MAX_POINTS_B,
  parameter int IDX_W        = 5,
  parameter int IDXA_W       = 5,
  parameter int IDXB_W       = 5,
  parameter int CNTA_W       = 6,
  parameter int CNTB_W       = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  cmd_t              cmd,
  input  logic [IDX_W-1:0]  a_addr,
  input  logic [IDX_W-1:0]  b_addr,
  output stat_t             stat,
  output logic [CNTA_W-1:0] a_count,
  output logic [CNTB_W-1:0] b_count,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int CB    = COORD_BITS;
  localparam int PT_W  = 2 * CB;
  localparam int SQ_W  = 2 * CB;
  localparam int D_W   = 2 * CB + 1;
  localparam int EXT_W = IDX_W + OUT_IDX_W;

  logic [CNTA_W-1:0] a_count_r, a_count_nxt;
  logic [CNTB_W-1:0] b_count_r, b_count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              a_full, b_full, a_empty, b_empty;
  logic              a_we, b_we;
  logic [PT_W-1:0]   in_pt;
  logic [PT_W-1:0]   a_rdata, b_rdata;
  logic [IDXA_W-1:0] na_rdata;

  logic [PT_W-1:0]   ref_r;

  logic              t0_valid_r, t1_valid_r, t2_valid_r;
  logic              t0_first_r, t1_first_r, t2_first_r;
  logic              t0_last_r, t1_last_r, t2_last_r;
  logic              t0_sel_b_r;
  logic [IDX_W-1:0]  t0_idx_r, t1_idx_r, t2_idx_r;

  logic [PT_W-1:0]   src_pt;
  logic [CB-1:0]     px, py, rx, ry;
  logic [CB-1:0]     dx_r, dy_r, dx_nxt, dy_nxt;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [D_W-1:0]    dist_sum;
  logic              take;
  logic [D_W-1:0]    best_d_r;
  logic [IDX_W-1:0]  best_i_r;
  logic              done_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              matched;
  logic [EXT_W-1:0]  pidx_ext, midx_ext;

  // Point loading and overflow tracking
  always_comb begin
    a_full      = (a_count_r == CNTA_W'(MAX_POINTS_A));
    b_full      = (b_count_r == CNTB_W'(MAX_POINTS_B));
    a_empty     = (a_count_r == '0);
    b_empty     = (b_count_r == '0);
    a_we        = cmd.load_a && !a_full;
    b_we        = cmd.load_b && !b_full;
    in_pt       = {in_data.point_x, in_data.point_y};
    a_count_nxt = a_count_r;
    b_count_nxt = b_count_r;
    ovf_nxt     = ovf_r;
    if (cmd.clear) begin
      a_count_nxt = '0;
      b_count_nxt = '0;
      ovf_nxt     = 1'b0;
    end else begin
      if (a_we) a_count_nxt = a_count_r + CNTA_W'(1);
      if (b_we) b_count_nxt = b_count_r + CNTB_W'(1);
      if ((cmd.load_a && a_full) || (cmd.load_b && b_full)) ovf_nxt = 1'b1;
    end
  end

  mnm_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS_A), .AW(IDXA_W)) u_set_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_count_r[IDXA_W-1:0]),
    .wdata (in_pt),
    .raddr (a_addr[IDXA_W-1:0]),
    .rdata (a_rdata)
  );

  mnm_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS_B), .AW(IDXB_W)) u_set_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_count_r[IDXB_W-1:0]),
    .wdata (in_pt),
    .raddr (b_addr[IDXB_W-1:0]),
    .rdata (b_rdata)
  );

  // Nearest A index for each B point
  mnm_ram #(.WIDTH(IDXA_W), .DEPTH(MAX_POINTS_B), .AW(IDXB_W)) u_nearest_a (
    .clk   (clk),
    .we    (cmd.wr_na),
    .waddr (b_addr[IDXB_W-1:0]),
    .wdata (best_i_r[IDXA_W-1:0]),
    .raddr (best_i_r[IDXB_W-1:0]),
    .rdata (na_rdata)
  );

  // Distance pipeline: offset-binary coordinates make unsigned order match signed
  always_comb begin
    src_pt   = t0_sel_b_r ? b_rdata : a_rdata;
    px       = {~src_pt[PT_W-1], src_pt[PT_W-2:CB]};
    py       = {~src_pt[CB-1], src_pt[CB-2:0]};
    rx       = {~ref_r[PT_W-1], ref_r[PT_W-2:CB]};
    ry       = {~ref_r[CB-1], ref_r[CB-2:0]};
    dx_nxt   = (px > rx) ? px - rx : rx - px;
    dy_nxt   = (py > ry) ? py - ry : ry - py;
    dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    take     = t2_first_r || (dist_sum < best_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_count_r   <= '0;
      b_count_r   <= '0;
      ovf_r       <= 1'b0;
      t0_valid_r  <= 1'b0;
      t1_valid_r  <= 1'b0;
      t2_valid_r  <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_count_r   <= a_count_nxt;
      b_count_r   <= b_count_nxt;
      ovf_r       <= ovf_nxt;
      t0_valid_r  <= cmd.scan_valid;
      t1_valid_r  <= t0_valid_r;
      t2_valid_r  <= t1_valid_r;
      done_r      <= t2_valid_r && t2_last_r;
      out_valid_r <= out_valid_nxt;
    end

    // Latch the outer point while the first inner read is issued
    if (cmd.latch_ref) begin
      ref_r <= cmd.phase2 ? a_rdata : b_rdata;
    end

    // Tags and data travel with each stage
    t0_first_r <= cmd.scan_first;
    t0_last_r  <= cmd.scan_last;
    t0_sel_b_r <= cmd.phase2;
    t0_idx_r   <= cmd.phase2 ? b_addr : a_addr;
    t1_first_r <= t0_first_r;
    t1_last_r  <= t0_last_r;
    t1_idx_r   <= t0_idx_r;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    t2_first_r <= t1_first_r;
    t2_last_r  <= t1_last_r;
    t2_idx_r   <= t1_idx_r;
    sqx_r      <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r      <= SQ_W'(dy_r) * SQ_W'(dy_r);

    // Keep the strictly nearer point, so the lowest index wins a tie
    if (t2_valid_r && take) begin
      best_d_r <= dist_sum;
      best_i_r <= t2_idx_r;
    end

    if (cmd.emit) begin
      out_data_r <= '{
        point_index: pidx_ext[OUT_IDX_W-1:0],
        match_index: matched ? midx_ext[OUT_IDX_W-1:0] : '0,
        matched:     matched,
        last:        cmd.emit_last,
        none_loaded: a_empty,
        overflowed:  ovf_r
      };
    end
  end

  // Result register: load on emit, drop once the transaction completes
  always_comb begin
    pidx_ext = EXT_W'(a_addr);
    midx_ext = EXT_W'(best_i_r);
    matched  = !a_empty && !b_empty && (na_rdata == a_addr[IDXA_W-1:0]);
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign stat.scan_done = done_r;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign a_count        = a_count_r;
  assign b_count        = b_count_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

### hdl/mutual_nearest_neighbour_match.sv
`timescale 1ns / 1ps

// Mutual nearest neighbor matcher for two planar point sets.
// Input channel (in_valid / in_stall / in_data): op 0 loads a point into
// set A, op 1 into set B, op 2 starts a run, op 3 is ignored. A load into
// a full set is dropped and raises the overflow flag.
// A run with NA A points and NB B points first scans all of A for every B
// point, then all of B for every A point, through one four-stage distance
// pipeline fed by the single read port of each point memory. With either
// set empty the scans are skipped. in_stall is high for the whole run.
// Output channel (out_valid / out_stall / out_data): one transaction per A
// point in index order, last set on the final one, or a single none_loaded
// marker when set A is empty. The run then clears both sets and the flag.
// A stalled result holds in the output register; the run pauses before the
// next result until the register is free.
// Reset (rst_n low, synchronous) empties both sets and clears the flag;
// point memories are not cleared.

module mutual_nearest_neighbour_match
  import mnm_pkg::*;
#(
  parameter int MAX_POINTS_A = MNM_MAX_POINTS_A,
  parameter int MAX_POINTS_B = MNM_MAX_POINTS_B
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDXA_W = $clog2(MAX_POINTS_A);
  localparam int IDXB_W = (MAX_POINTS_B > 1) ? $clog2(MAX_POINTS_B) : 1;
  localparam int IDX_W  = (IDXA_W > IDXB_W) ? IDXA_W : IDXB_W;
  localparam int CNTA_W = $clog2(MAX_POINTS_A + 1);
  localparam int CNTB_W = $clog2(MAX_POINTS_B + 1);

  cmd_t              cmd;
  stat_t             stat;
  logic [IDX_W-1:0]  a_addr, b_addr;
  logic [CNTA_W-1:0] a_count;
  logic [CNTB_W-1:0] b_count;

  mnm_ctrl #(
    .IDX_W  (IDX_W),
    .CNTA_W (CNTA_W),
    .CNTB_W (CNTB_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .a_count  (a_count),
    .b_count  (b_count),
    .stat     (stat),
    .cmd      (cmd),
    .a_addr   (a_addr),
    .b_addr   (b_addr)
  );

  mnm_dp #(
    .MAX_POINTS_A (MAX_POINTS_A),
    .MAX_POINTS_B (MAX_POINTS_B),
    .IDX_W        (IDX_W),
    .IDXA_W       (IDXA_W),
    .IDXB_W       (IDXB_W),
    .CNTA_W       (CNTA_W),
    .CNTB_W       (CNTB_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .stat      (stat),
    .a_count   (a_count),
    .b_count   (b_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mnm_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         RANDOM_ITEMS = 150;
  localparam int         TAIL_CYCLES = 300;

  typedef struct {
    in_item_t item;
    bit       wait_idle;  // hold this transaction until no result is outstanding
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  stim_t     point_stream[$];
  out_item_t match_queue[$];

  // Shadow copy of both point sets
  logic signed [COORD_BITS-1:0] a_x [MNM_MAX_POINTS_A];
  logic signed [COORD_BITS-1:0] a_y [MNM_MAX_POINTS_A];
  logic signed [COORD_BITS-1:0] b_x [MNM_MAX_POINTS_B];
  logic signed [COORD_BITS-1:0] b_y [MNM_MAX_POINTS_B];
  int a_count = 0;
  int b_count = 0;
  bit overflow_seen = 1'b0;

  int presented_count = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_hold = 0;

  mutual_nearest_neighbour_match i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact squared distance; fits easily in 64 bits
  function automatic longint dist_sq(logic signed [COORD_BITS-1:0] px,
                                     logic signed [COORD_BITS-1:0] py,
                                     logic signed [COORD_BITS-1:0] qx,
                                     logic signed [COORD_BITS-1:0] qy);
    longint dx, dy;
    dx = longint'(px) - longint'(qx);
    dy = longint'(py) - longint'(qy);
    return dx * dx + dy * dy;
  endfunction

  // Nearest point of set B (in_b) or set A to (px, py); lowest index wins a tie
  function automatic int nearest_of(bit in_b, logic signed [COORD_BITS-1:0] px,
                                    logic signed [COORD_BITS-1:0] py);
    int best, cnt;
    longint best_d, d;
    cnt = in_b ? b_count : a_count;
    best = 0;
    best_d = -1;
    for (int i = 0; i < cnt; i++) begin
      d = in_b ? dist_sq(b_x[i], b_y[i], px, py) : dist_sq(a_x[i], a_y[i], px, py);
      if (best_d < 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  // Update the shadow sets and queue the results a transaction causes
  task automatic predict_matches(in_item_t t);
    int nearest_a_of_b [MNM_MAX_POINTS_B];
    int nb;
    out_item_t r;
    case (t.op)
      OP_LOAD_A: begin
        if (a_count < MNM_MAX_POINTS_A) begin
          a_x[a_count] = t.point_x;
          a_y[a_count] = t.point_y;
          a_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (b_count < MNM_MAX_POINTS_B) begin
          b_x[b_count] = t.point_x;
          b_y[b_count] = t.point_y;
          b_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      OP_RUN: begin
        if (a_count == 0) begin
          r = '0;
          r.last = 1'b1;
          r.none_loaded = 1'b1;
          r.overflowed = overflow_seen;
          match_queue = {match_queue, r};
        end else begin
          for (int b = 0; b < b_count; b++)
            nearest_a_of_b[b] = nearest_of(1'b0, b_x[b], b_y[b]);
          for (int a = 0; a < a_count; a++) begin
            r = '0;
            r.point_index = a[OUT_IDX_W-1:0];
            if (b_count > 0) begin
              nb = nearest_of(1'b1, a_x[a], a_y[a]);
              if (nearest_a_of_b[nb] == a) begin
                r.matched = 1'b1;
                r.match_index = nb[OUT_IDX_W-1:0];
              end
            end
            r.last = (a == a_count - 1);
            r.overflowed = overflow_seen;
            match_queue = {match_queue, r};
          end
        end
        a_count = 0;
        b_count = 0;
        overflow_seen = 1'b0;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  task automatic queue_item(logic [1:0] op, logic [COORD_BITS-1:0] x,
                            logic [COORD_BITS-1:0] y, bit wait_idle);
    stim_t s;
    s.item.op = op;
    s.item.point_x = x;
    s.item.point_y = y;
    s.wait_idle = wait_idle;
    point_stream = {point_stream, s};
  endtask

  // Coordinate by style: full range, tight cluster (ties), or extremes
  function automatic logic [COORD_BITS-1:0] pick_coord(int style);
    logic [COORD_BITS-1:0] v;
    case (style)
      0: v = COORD_BITS'($urandom);
      1: v = COORD_BITS'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = COORD_BITS'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  // Pick a set size: mostly small, some large, a few past capacity
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 80) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 31);
    return $urandom_range(32, 35);
  endfunction

  task automatic queue_sequence(int na, int nb, int style);
    int la, lb;
    la = 0;
    lb = 0;
    while (la < na || lb < nb) begin
      if ($urandom_range(0, 19) == 0)
        queue_item(OP_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
      if (lb >= nb || (la < na && $urandom_range(0, 1) == 0)) begin
        queue_item(OP_LOAD_A, pick_coord(style), pick_coord(style), 1'b0);
        la++;
      end else begin
        queue_item(OP_LOAD_B, pick_coord(style), pick_coord(style), 1'b0);
        lb++;
      end
    end
    queue_item(OP_RUN, COORD_BITS'($urandom), COORD_BITS'($urandom),
               $urandom_range(0, 6) == 0);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int random_items;
    int na, nb;

    // Both sets empty, then an unused code
    queue_item(OP_RUN, 16'h0000, 16'h0000, 1'b0);
    queue_item(OP_UNUSED, 16'h7fff, 16'h8000, 1'b0);
    // Set A empty with set B loaded: marker, set B cleared
    queue_item(OP_LOAD_B, 16'h0000, 16'h0000, 1'b0);
    queue_item(OP_RUN, 16'hffff, 16'hffff, 1'b0);
    // Set B empty: every A point unmatched
    queue_item(OP_LOAD_A, 16'h8000, 16'h8000, 1'b0);
    queue_item(OP_LOAD_A, 16'h7fff, 16'h7fff, 1'b0);
    queue_item(OP_RUN, 16'h0000, 16'h0000, 1'b0);
    // Largest possible distance
    queue_item(OP_LOAD_A, 16'h8000, 16'h8000, 1'b0);
    queue_item(OP_LOAD_B, 16'h7fff, 16'h7fff, 1'b0);
    queue_item(OP_LOAD_B, 16'h8000, 16'h7fff, 1'b0);
    queue_item(OP_RUN, 16'h0000, 16'h0000, 1'b0);
    // Ties both ways: lowest index wins, second A point left unmatched
    queue_item(OP_LOAD_A, 16'h0000, 16'h0000, 1'b0);
    queue_item(OP_LOAD_A, 16'h0002, 16'h0000, 1'b0);
    queue_item(OP_LOAD_B, 16'h0001, 16'h0000, 1'b0);
    queue_item(OP_LOAD_B, 16'h0001, 16'h0000, 1'b0);
    queue_item(OP_RUN, 16'h0000, 16'h0000, 1'b1);
    // One mutual pair, one A point whose nearest B point prefers another
    queue_item(OP_LOAD_A, 16'h0000, 16'h0000, 1'b0);
    queue_item(OP_UNUSED, 16'h0000, 16'h0000, 1'b0);
    queue_item(OP_LOAD_A, 16'h000a, 16'h0000, 1'b0);
    queue_item(OP_LOAD_B, 16'h0004, 16'h0000, 1'b0);
    queue_item(OP_RUN, 16'h0000, 16'h0000, 1'b0);

    // Random part: start with both sets overfilled
    queue_sequence(34, 33, 0);
    random_items = 68;
    while (random_items < RANDOM_ITEMS) begin
      na = pick_size();
      nb = pick_size();
      queue_sequence(na, nb, $urandom_range(0, 2));
      random_items += na + nb + 1;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (point_stream.size() != 0 || presented_count != accepted_count ||
           match_queue.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Predict on each accepted transaction, then check each accepted result
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && in_valid && !in_stall) begin
      predict_matches(in_data);
      accepted_count <= accepted_count + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (match_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: idx=%0d match=%0d m=%b last=%b none=%b ovf=%b",
                   out_data.point_index, out_data.match_index, out_data.matched,
                   out_data.last, out_data.none_loaded, out_data.overflowed);
      end else begin
        exp_r = match_queue.pop_front();
        if (out_data.point_index !== exp_r.point_index ||
            out_data.match_index !== exp_r.match_index ||
            out_data.matched !== exp_r.matched || out_data.last !== exp_r.last ||
            out_data.none_loaded !== exp_r.none_loaded ||
            out_data.overflowed !== exp_r.overflowed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected idx=%0d match=%0d m=%b last=%b none=%b ovf=%b,",
                      " got idx=%0d match=%0d m=%b last=%b none=%b ovf=%b"},
                     exp_r.point_index, exp_r.match_index, exp_r.matched,
                     exp_r.last, exp_r.none_loaded, exp_r.overflowed,
                     out_data.point_index, out_data.match_index, out_data.matched,
                     out_data.last, out_data.none_loaded, out_data.overflowed);
        end
      end
    end
  end

  // Send transactions in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && presented_count != accepted_count) begin
      // hold the stalled transaction
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (point_stream.size() == 0 ||
                 (point_stream[0].wait_idle && match_queue.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_data <= point_stream[0].item;
      point_stream.pop_front();
      presented_count <= presented_count + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        case ($urandom_range(0, 9))
          0, 1, 2: gap_left <= 0;
          9:       gap_left <= $urandom_range(5, 40);
          default: gap_left <= $urandom_range(1, 4);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Stall results: free-running, random, or long on/off stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_hold == 0) begin
          out_stall <= !out_stall;
          stall_hold <= $urandom_range(1, 25);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
    endcase
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
